// ===== rtl/pdrgb_pkg.sv =====
`timescale 1ns / 1ps

package pdrgb_pkg;

    // widths fixed by the register map and the result word
    localparam int LIMIT_BITS     = 16;
    localparam int STEP_BITS      = 8;
    localparam int OUT_LEVEL_BITS = 8;
    localparam int COLOR_BITS     = 3;
    localparam int CHAN_BITS      = 2;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    // default parameter values
    localparam int COUNT_BITS_DEFAULT = 16;
    localparam int LEVEL_BITS_DEFAULT = 8;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_SHORT_LIMIT = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RED_LIMIT   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GREEN_LIMIT = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BLUE_LIMIT  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL_STEP  = 3'd4;

    // register reset values
    localparam logic [LIMIT_BITS-1:0] SHORT_LIMIT_RESET = 16'd500;
    localparam logic [LIMIT_BITS-1:0] RED_LIMIT_RESET   = 16'd1000;
    localparam logic [LIMIT_BITS-1:0] GREEN_LIMIT_RESET = 16'd1500;
    localparam logic [LIMIT_BITS-1:0] BLUE_LIMIT_RESET  = 16'd2000;
    localparam logic [STEP_BITS-1:0]  LEVEL_STEP_RESET  = 8'd16;

    // preset colors, also the duration classes
    localparam logic [COLOR_BITS-1:0] COLOR_WHITE = 3'd0;
    localparam logic [COLOR_BITS-1:0] COLOR_RED   = 3'd1;
    localparam logic [COLOR_BITS-1:0] COLOR_GREEN = 3'd2;
    localparam logic [COLOR_BITS-1:0] COLOR_BLUE  = 3'd3;
    localparam logic [COLOR_BITS-1:0] COLOR_BLACK = 3'd4;

    // channel codes
    localparam logic [CHAN_BITS-1:0] CHAN_RED   = 2'd0;
    localparam logic [CHAN_BITS-1:0] CHAN_GREEN = 2'd1;
    localparam logic [CHAN_BITS-1:0] CHAN_BLUE  = 2'd2;

    typedef struct packed {
        logic [LIMIT_BITS-1:0] short_limit;
        logic [LIMIT_BITS-1:0] red_limit;
        logic [LIMIT_BITS-1:0] green_limit;
        logic [LIMIT_BITS-1:0] blue_limit;
        logic [STEP_BITS-1:0]  level_step;
    } cfg_t;

    typedef struct packed {
        logic                      show_levels;
        logic [COLOR_BITS-1:0]     preset_color;
        logic [OUT_LEVEL_BITS-1:0] red_out;
        logic [OUT_LEVEL_BITS-1:0] green_out;
        logic [OUT_LEVEL_BITS-1:0] blue_out;
        logic [CHAN_BITS-1:0]      chosen_channel;
    } result_t;

endpackage

// ===== rtl/pdrgb_cfg_regs.sv =====
`timescale 1ns / 1ps

module pdrgb_cfg_regs
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pdrgb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [pdrgb_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output pdrgb_pkg::cfg_t                      cfg
);

    pdrgb_pkg::cfg_t cfg_reg;
    pdrgb_pkg::cfg_t cfg_next;

    // writes are always accepted and take effect at the next clock edge
    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // register decode, unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                pdrgb_pkg::REG_SHORT_LIMIT:
                    cfg_next.short_limit = pdrgb_pkg::LIMIT_BITS'(cfg_data);
                pdrgb_pkg::REG_RED_LIMIT:
                    cfg_next.red_limit = pdrgb_pkg::LIMIT_BITS'(cfg_data);
                pdrgb_pkg::REG_GREEN_LIMIT:
                    cfg_next.green_limit = pdrgb_pkg::LIMIT_BITS'(cfg_data);
                pdrgb_pkg::REG_BLUE_LIMIT:
                    cfg_next.blue_limit = pdrgb_pkg::LIMIT_BITS'(cfg_data);
                pdrgb_pkg::REG_LEVEL_STEP:
                    cfg_next.level_step = cfg_data[pdrgb_pkg::STEP_BITS-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_limit <= pdrgb_pkg::SHORT_LIMIT_RESET;
            cfg_reg.red_limit   <= pdrgb_pkg::RED_LIMIT_RESET;
            cfg_reg.green_limit <= pdrgb_pkg::GREEN_LIMIT_RESET;
            cfg_reg.blue_limit  <= pdrgb_pkg::BLUE_LIMIT_RESET;
            cfg_reg.level_step  <= pdrgb_pkg::LEVEL_STEP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/pdrgb_tick_core.sv =====
`timescale 1ns / 1ps

module pdrgb_tick_core
#(
    parameter int COUNT_BITS = pdrgb_pkg::COUNT_BITS_DEFAULT,
    parameter int LEVEL_BITS = pdrgb_pkg::LEVEL_BITS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               down,
    input  pdrgb_pkg::cfg_t    cfg,
    output pdrgb_pkg::result_t result
);

    localparam int CMP_BITS = (COUNT_BITS > pdrgb_pkg::LIMIT_BITS) ?
                              COUNT_BITS : pdrgb_pkg::LIMIT_BITS;
    localparam int SUM_BITS = (LEVEL_BITS > pdrgb_pkg::STEP_BITS) ?
                              LEVEL_BITS : pdrgb_pkg::STEP_BITS;
    localparam int NUM_CHAN = 3;

    logic                              held_reg;
    logic                              held_next;
    logic [COUNT_BITS-1:0]             ticks_reg;
    logic [COUNT_BITS-1:0]             ticks_next;
    logic [pdrgb_pkg::CHAN_BITS-1:0]   sel_reg;
    logic [pdrgb_pkg::CHAN_BITS-1:0]   sel_next;
    logic [LEVEL_BITS-1:0]             level_reg  [NUM_CHAN];
    logic [LEVEL_BITS-1:0]             level_next [NUM_CHAN];
    logic [LEVEL_BITS-1:0]             level_sum  [NUM_CHAN];
    logic [CMP_BITS-1:0]               ticks_cmp;
    logic [pdrgb_pkg::COLOR_BITS-1:0]  dur_class;
    logic                              release_now;

    // saturating press counter
    always_comb
    begin
        if (!held_reg)
            ticks_next = '0;
        else if (&ticks_reg)
            ticks_next = ticks_reg;
        else
            ticks_next = ticks_reg + COUNT_BITS'(1);
    end

    // duration class, first limit above the count wins
    assign ticks_cmp = CMP_BITS'(ticks_next);

    always_comb
    begin
        if (ticks_cmp < CMP_BITS'(cfg.short_limit))
            dur_class = pdrgb_pkg::COLOR_WHITE;
        else if (ticks_cmp < CMP_BITS'(cfg.red_limit))
            dur_class = pdrgb_pkg::COLOR_RED;
        else if (ticks_cmp < CMP_BITS'(cfg.green_limit))
            dur_class = pdrgb_pkg::COLOR_GREEN;
        else if (ticks_cmp < CMP_BITS'(cfg.blue_limit))
            dur_class = pdrgb_pkg::COLOR_BLUE;
        else
            dur_class = pdrgb_pkg::COLOR_BLACK;
    end

    assign release_now = held_reg && !down;
    assign held_next   = held_reg ? down : down;

    // level step per channel, wraps at the level width
    always_comb
    begin
        for (int i = 0; i < NUM_CHAN; i++)
        begin
            level_sum[i] = LEVEL_BITS'(SUM_BITS'(level_reg[i]) + SUM_BITS'(cfg.level_step));
        end
    end

    // release action
    always_comb
    begin
        sel_next = sel_reg;
        for (int i = 0; i < NUM_CHAN; i++)
        begin
            level_next[i] = level_reg[i];
        end
        if (release_now)
        begin
            case (dur_class)
                pdrgb_pkg::COLOR_WHITE:
                begin
                    for (int i = 0; i < NUM_CHAN; i++)
                    begin
                        if (sel_reg == pdrgb_pkg::CHAN_BITS'(i))
                            level_next[i] = level_sum[i];
                    end
                end
                pdrgb_pkg::COLOR_RED:   sel_next = pdrgb_pkg::CHAN_RED;
                pdrgb_pkg::COLOR_GREEN: sel_next = pdrgb_pkg::CHAN_GREEN;
                pdrgb_pkg::COLOR_BLUE:  sel_next = pdrgb_pkg::CHAN_BLUE;
                default:
                begin
                    for (int i = 0; i < NUM_CHAN; i++)
                    begin
                        level_next[i] = '0;
                    end
                end
            endcase
        end
    end

    // result word for this tick
    always_comb
    begin
        result.show_levels    = !held_reg;
        result.preset_color   = held_reg ? dur_class : pdrgb_pkg::COLOR_WHITE;
        result.red_out        = pdrgb_pkg::OUT_LEVEL_BITS'(level_next[0]);
        result.green_out      = pdrgb_pkg::OUT_LEVEL_BITS'(level_next[1]);
        result.blue_out       = pdrgb_pkg::OUT_LEVEL_BITS'(level_next[2]);
        result.chosen_channel = sel_next;
    end

    // state registers move only when a word is processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= 1'b0;
            ticks_reg <= '0;
            sel_reg   <= pdrgb_pkg::CHAN_RED;
            for (int i = 0; i < NUM_CHAN; i++)
            begin
                level_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            held_reg  <= held_next;
            ticks_reg <= ticks_next;
            sel_reg   <= sel_next;
            for (int i = 0; i < NUM_CHAN; i++)
            begin
                level_reg[i] <= level_next[i];
            end
        end
    end

endmodule

// ===== rtl/press_duration_rgb_level_control_core.sv =====
`timescale 1ns / 1ps

// Press-duration RGB level control. Each input word is one timer tick with the
// sampled button level; each tick yields exactly one result word. While the
// button is held a saturating counter runs and a preset color (white, red,
// green, blue, black) is chosen against four programmable limits; on release
// the same class adds level_step to the selected channel, selects red, green
// or blue, or clears all levels. Throughput is one word per clock while the
// output side is not stalled; a word passes an input register, the
// combinational tick logic and a result register, in that order. Limits and
// step are to be written by the user through the cfg port only while the block
// is idle; the block does not enforce this. Unknown-index writes are dropped.

module press_duration_rgb_level_control_core
#(
    parameter int COUNT_BITS = pdrgb_pkg::COUNT_BITS_DEFAULT,
    parameter int LEVEL_BITS = pdrgb_pkg::LEVEL_BITS_DEFAULT
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 button_down,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 show_levels,
    output logic [pdrgb_pkg::COLOR_BITS-1:0]     preset_color,
    output logic [pdrgb_pkg::OUT_LEVEL_BITS-1:0] red_out,
    output logic [pdrgb_pkg::OUT_LEVEL_BITS-1:0] green_out,
    output logic [pdrgb_pkg::OUT_LEVEL_BITS-1:0] blue_out,
    output logic [pdrgb_pkg::CHAN_BITS-1:0]      chosen_channel,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pdrgb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [pdrgb_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    pdrgb_pkg::cfg_t    cfg;
    pdrgb_pkg::result_t result;
    pdrgb_pkg::result_t result_reg;
    logic               in_valid_reg;
    logic               down_reg;
    logic               out_valid_reg;
    logic               advance;

    // a word moves on when the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    pdrgb_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pdrgb_tick_core
    #(
        .COUNT_BITS (COUNT_BITS),
        .LEVEL_BITS (LEVEL_BITS)
    )
    u_tick_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .down    (down_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            down_reg <= button_down;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign show_levels    = result_reg.show_levels;
    assign preset_color   = result_reg.preset_color;
    assign red_out        = result_reg.red_out;
    assign green_out      = result_reg.green_out;
    assign blue_out       = result_reg.blue_out;
    assign chosen_channel = result_reg.chosen_channel;

endmodule
